[design/bounded_set_table_assert.svh]
// Assertion macros for the bounded set table.
// Every check is clocked on clk and held off while arst_n is low.
`ifndef BOUNDED_SET_TABLE_ASSERT_SVH
`define BOUNDED_SET_TABLE_ASSERT_SVH

// Property that must hold at every clock edge.
`define BST_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// A condition at one edge forces an outcome at the next.
`define BST_ASSERT_NEXT(lbl, cond, nxt, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (nxt)) else $error(msg);

`endif

[design/bst_pkg.sv]
package bst_pkg;

	localparam int OPCODE_W = 2;
	localparam int ELEM_W = 32;
	localparam int COUNT_W = 7;
	localparam int CAPACITY_DEF = 64;

	localparam logic [OPCODE_W-1:0] OP_ADD = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_REMOVE = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_SEARCH = 2'd2;

	// Lookup token walking down the cell chain.
	typedef struct packed {
		logic vld;
		logic [OPCODE_W-1:0] op;
		logic [ELEM_W-1:0] value;
		logic found;
	} bst_token_t;

endpackage

[design/bst_cell.sv]
module bst_cell #(
	parameter int CNT_W = 7,
	parameter int INDEX = 0
) (
	input logic clk,
	input logic arst_n,
	input logic [CNT_W-1:0] count,
	input bst_pkg::bst_token_t tok_in,
	output bst_pkg::bst_token_t tok_out,
	input logic [bst_pkg::ELEM_W-1:0] next_entry,
	output logic [bst_pkg::ELEM_W-1:0] entry
);

	localparam logic [CNT_W-1:0] IDX = CNT_W'(INDEX);

	logic [bst_pkg::ELEM_W-1:0] entry_q;
	bst_pkg::bst_token_t tok_q;
	bst_pkg::bst_token_t tok_nxt;
	logic live;
	logic hit;
	logic add_wr;
	logic shift_dn;

	assign live = IDX < count;
	assign hit = tok_in.vld && live && (entry_q == tok_in.value);
	// first free slot takes a new value if nobody upstream holds it
	assign add_wr = tok_in.vld && (tok_in.op == bst_pkg::OP_ADD) && !tok_in.found
		&& (IDX == count);
	// at and after the removed slot every entry pulls from its neighbor
	assign shift_dn = tok_in.vld && (tok_in.op == bst_pkg::OP_REMOVE) && (tok_in.found || hit);

	always_comb begin
		tok_nxt = tok_in;
		tok_nxt.found = tok_in.found || hit;
	end

	always_ff @(posedge clk) begin
		if (add_wr) begin
			entry_q <= tok_in.value;
		end else if (shift_dn) begin
			entry_q <= next_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_nxt;
		end
	end

	assign tok_out = tok_q;
	assign entry = entry_q;

endmodule

[design/bounded_set_table.sv]
// Bounded set table: a set of distinct 32-bit values kept packed in a
// chain of CAPACITY cells, one stored value per cell, plus a count.
//
// Command channel: opcode (add, remove, search) and element are taken
// at a rising edge with start high and busy low. busy stays high while
// the transaction is in flight; no new command is taken then.
// Result channel: success, full_reject and count are valid for exactly
// one cycle while done is high. The receiver cannot hold results off.
//
// The accepting edge loads the token register; the token then passes the
// register of every cell in turn, and done is registered from the token
// leaving the last cell. One transaction is in flight at a time.
// The lookup token steps through one cell per cycle; every cell compares
// it against its stored value, the first free cell appends on add, and
// cells at and past a hit pull down their neighbor on remove, so the
// table stays packed.
// A new command may be accepted at the edge that ends the done cycle.
//
// Reset clears the count, the busy flag and the token chain; stored
// values are not cleared, only cells below the count are ever matched.
`include "bounded_set_table_assert.svh"

module bounded_set_table #(
	parameter int CAPACITY = bst_pkg::CAPACITY_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic [bst_pkg::OPCODE_W-1:0] opcode,
	input logic signed [bst_pkg::ELEM_W-1:0] element,
	output logic done,
	output logic success,
	output logic full_reject,
	output logic [bst_pkg::COUNT_W-1:0] count
);

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

	logic busy_q;
	logic done_q;
	logic success_q;
	logic full_q;
	logic [CNT_W-1:0] cnt_q;
	bst_pkg::bst_token_t tok_q;

	bst_pkg::bst_token_t tok_chain [CAPACITY+1];
	logic [bst_pkg::ELEM_W-1:0] ent [CAPACITY];
	logic [bst_pkg::ELEM_W-1:0] nxt [CAPACITY];
	logic [CAPACITY:0] tok_vld;

	logic accept;
	bst_pkg::bst_token_t tok_end;
	logic is_add;
	logic is_rem;
	logic add_ok;
	logic add_full;
	logic fin_ok;
	logic [CNT_W+bst_pkg::COUNT_W-1:0] cnt_wide;

	assign accept = start && !busy_q;
	assign tok_chain[0] = tok_q;
	assign tok_end = tok_chain[CAPACITY];

	// cell chain: token in at cell 0, out after the last cell
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		if (i == CAPACITY - 1) begin : g_last
			assign nxt[i] = ent[i];
		end else begin : g_mid
			assign nxt[i] = ent[i+1];
		end

		bst_cell #(
			.CNT_W(CNT_W),
			.INDEX(i)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.count(cnt_q),
			.tok_in(tok_chain[i]),
			.tok_out(tok_chain[i+1]),
			.next_entry(nxt[i]),
			.entry(ent[i])
		);
	end

	for (genvar k = 0; k <= CAPACITY; k++) begin : g_vld
		assign tok_vld[k] = tok_chain[k].vld;
	end

	// outcome once the token has passed every cell
	assign is_add = tok_end.op == bst_pkg::OP_ADD;
	assign is_rem = tok_end.op == bst_pkg::OP_REMOVE;
	assign add_ok = is_add && !tok_end.found && (cnt_q < CAP_CNT);
	assign add_full = is_add && !tok_end.found && (cnt_q == CAP_CNT);
	assign fin_ok = add_ok || ((is_rem || (tok_end.op == bst_pkg::OP_SEARCH)) && tok_end.found);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			success_q <= 1'b0;
			full_q <= 1'b0;
			cnt_q <= '0;
			tok_q <= '0;
		end else begin
			done_q <= tok_end.vld;
			if (accept) begin
				busy_q <= 1'b1;
				tok_q <= '{vld: 1'b1, op: opcode, value: element, found: 1'b0};
			end else begin
				tok_q.vld <= 1'b0;
				if (tok_end.vld) begin
					busy_q <= 1'b0;
				end
			end
			if (tok_end.vld) begin
				success_q <= fin_ok;
				full_q <= add_full;
				if (add_ok) begin
					cnt_q <= cnt_q + CNT_W'(1);
				end else if (is_rem && tok_end.found) begin
					cnt_q <= cnt_q - CNT_W'(1);
				end
			end
		end
	end

	// count port reports the stored count modulo 128
	assign cnt_wide = {{bst_pkg::COUNT_W{1'b0}}, cnt_q};

	assign busy = busy_q;
	assign done = done_q;
	assign success = success_q;
	assign full_reject = full_q;
	assign count = cnt_wide[bst_pkg::COUNT_W-1:0];

	`BST_ASSERT(a_one_token, $onehot0(tok_vld), "more than one token in the cell chain")
	`BST_ASSERT(a_cnt_bound, cnt_q <= CAP_CNT, "stored count exceeds capacity")
	`BST_ASSERT(a_done_idle, !done_q || !busy_q, "result shown while still busy")
	`BST_ASSERT(a_full_fail, !(full_q && success_q), "full reject with success")
	`BST_ASSERT_NEXT(a_acc_busy, accept, busy_q && tok_q.vld, "accepted command not launched")

endmodule

[tb/bounded_set_table_checker.sv]
`timescale 1ns / 100ps

module bounded_set_table_checker #(
	parameter int CAPACITY = bst_pkg::CAPACITY_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic [bst_pkg::OPCODE_W-1:0] opcode,
	input logic [bst_pkg::ELEM_W-1:0] element,
	input logic done,
	input logic success,
	input logic full_reject,
	input logic [bst_pkg::COUNT_W-1:0] count,
	output int mismatches,
	output int pending
);

	typedef struct packed {
		logic success;
		logic full_reject;
		logic [bst_pkg::COUNT_W-1:0] count;
	} set_outcome_t;

	// shadow copy of the packed table
	logic [bst_pkg::ELEM_W-1:0] members [CAPACITY];
	int member_count;
	int fault_total;
	set_outcome_t expected_outcomes [$];

	function automatic set_outcome_t apply_set_op(logic [bst_pkg::OPCODE_W-1:0] op,
		logic [bst_pkg::ELEM_W-1:0] value);
		set_outcome_t r;
		int pos;
		r = '0;
		pos = -1;
		for (int i = 0; i < member_count; i++) begin
			if (pos < 0 && members[i] == value)
				pos = i;
		end
		case (op)
		bst_pkg::OP_ADD: begin
			if (pos < 0) begin
				if (member_count >= CAPACITY) begin
					r.full_reject = 1'b1;
				end else begin
					members[member_count] = value;
					member_count++;
					r.success = 1'b1;
				end
			end
		end
		bst_pkg::OP_REMOVE: begin
			if (pos >= 0) begin
				for (int j = pos; j + 1 < member_count; j++)
					members[j] = members[j + 1];
				member_count--;
				r.success = 1'b1;
			end
		end
		bst_pkg::OP_SEARCH: begin
			r.success = (pos >= 0);
		end
		default: ;
		endcase
		r.count = member_count[bst_pkg::COUNT_W-1:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		set_outcome_t want;
		if (!arst_n) begin
			member_count = 0;
			fault_total = 0;
			expected_outcomes.delete();
			mismatches <= 0;
			pending <= 0;
		end else begin
			// result first: a new command may be taken on the done cycle
			if (done === 1'b1) begin
				if (expected_outcomes.size() == 0) begin
					$error("result seen with no transaction outstanding");
					fault_total++;
				end else begin
					want = expected_outcomes.pop_front();
					if (success !== want.success) begin
						$error("success: expected %0d, got %0d", want.success, success);
						fault_total++;
					end
					if (full_reject !== want.full_reject) begin
						$error("full_reject: expected %0d, got %0d",
							want.full_reject, full_reject);
						fault_total++;
					end
					if (count !== want.count) begin
						$error("count: expected %0d, got %0d", want.count, count);
						fault_total++;
					end
				end
			end
			if (start === 1'b1 && busy === 1'b0)
				expected_outcomes.push_back(apply_set_op(opcode, element));
			mismatches <= fault_total;
			pending <= expected_outcomes.size();
		end
	end

endmodule

[tb/bounded_set_table_test.sv]
`timescale 1ns / 100ps

module bounded_set_table_test;

	localparam int TABLE_DEPTH = bst_pkg::CAPACITY_DEF;
	// opcode value with no operation behind it
	localparam logic [bst_pkg::OPCODE_W-1:0] OP_UNUSED = 2'd3;
	localparam int RANDOM_ITEMS = 700;
	localparam int POOL_SIZE = 80;

	logic clk;
	logic arst_n;
	logic start;
	logic [bst_pkg::OPCODE_W-1:0] opcode;
	logic signed [bst_pkg::ELEM_W-1:0] element;
	logic busy;
	logic done;
	logic success;
	logic full_reject;
	logic [bst_pkg::COUNT_W-1:0] count;
	int mismatches;
	int pending;

	// sender idling on/off; off for directed items and for phase 3
	bit idling_on;
	logic [bst_pkg::ELEM_W-1:0] value_pool [POOL_SIZE];

	bounded_set_table dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.opcode(opcode),
		.element(element),
		.done(done),
		.success(success),
		.full_reject(full_reject),
		.count(count)
	);

	// Scoreboard sits beside the DUT: it sees every accepted command and
	// every done strobe, runs its own copy of the table, and reports back.
	bounded_set_table_checker #(.CAPACITY(TABLE_DEPTH)) checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.opcode(opcode),
		.element(element),
		.done(done),
		.success(success),
		.full_reject(full_reject),
		.count(count),
		.mismatches(mismatches),
		.pending(pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 0;
	end

	// One command transaction. Start is raised at an edge and held until
	// an edge sees busy low; that edge takes the command. Busy is read right
	// after the edge, so it still holds its pre-edge value. When idling,
	// start sometimes drops for a random gap long enough to land anywhere
	// in the block's lookup.
	task automatic issue_command(input logic [bst_pkg::OPCODE_W-1:0] op,
		input logic [bst_pkg::ELEM_W-1:0] value);
		start <= 1'b1;
		opcode <= op;
		element <= value;
		@(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
		if (idling_on && $urandom_range(99) < 30) begin
			start <= 1'b0;
			repeat ($urandom_range(1, TABLE_DEPTH + 16)) @(posedge clk);
		end
	endtask

	// Hold off the sender until the checker has nothing outstanding.
	// Advance first: pending is registered, so it lags the accept.
	task automatic wait_for_quiet;
		start <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
	endtask

	initial begin
		int sent;
		int phase;
		int phase_len;
		int add_cut;
		int remove_cut;
		int pick;
		logic [bst_pkg::OPCODE_W-1:0] op;
		logic [bst_pkg::ELEM_W-1:0] value;

		clk = 0;
		arst_n = 0;
		start = 0;
		opcode = bst_pkg::OP_ADD;
		element = 0;
		idling_on = 0;

		// extremes first, the rest random; small pool so hits are common
		value_pool[0] = 32'h8000_0000;
		value_pool[1] = 32'h7FFF_FFFF;
		value_pool[2] = 32'h0000_0000;
		value_pool[3] = 32'hFFFF_FFFF;
		for (int i = 4; i < POOL_SIZE; i++)
			value_pool[i] = $urandom();

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// --- directed ---
		issue_command(bst_pkg::OP_SEARCH, 32'h0000_0000);    // search on empty table
		issue_command(bst_pkg::OP_REMOVE, 32'h0000_0005);    // remove from empty table
		issue_command(bst_pkg::OP_ADD, 32'h8000_0000);       // most negative
		issue_command(bst_pkg::OP_ADD, 32'h7FFF_FFFF);       // most positive
		issue_command(bst_pkg::OP_ADD, 32'h0000_0000);
		issue_command(bst_pkg::OP_ADD, 32'hFFFF_FFFF);
		issue_command(bst_pkg::OP_ADD, 32'h0000_0001);
		issue_command(bst_pkg::OP_ADD, 32'h8000_0000);       // duplicate add
		issue_command(bst_pkg::OP_SEARCH, 32'h7FFF_FFFF);    // hit
		issue_command(bst_pkg::OP_SEARCH, 32'h1234_5678);    // miss
		issue_command(bst_pkg::OP_REMOVE, 32'h0000_0000);    // middle entry, shift down
		issue_command(bst_pkg::OP_REMOVE, 32'h0000_0000);    // now absent
		issue_command(bst_pkg::OP_SEARCH, 32'hFFFF_FFFF);    // moved entry still found
		issue_command(bst_pkg::OP_REMOVE, 32'h8000_0000);    // first entry
		issue_command(bst_pkg::OP_REMOVE, 32'h0000_0001);    // last entry
		issue_command(OP_UNUSED, 32'hA5A5_A5A5);             // no-op opcode
		issue_command(bst_pkg::OP_ADD, 32'h5A5A_5A5A);
		issue_command(bst_pkg::OP_SEARCH, 32'h5A5A_5A5A);
		issue_command(OP_UNUSED, 32'h5A5A_5A5A);             // no-op on a present value
		wait_for_quiet();

		// --- random phases ---
		// Rotate fill / drain / mixed mixes. Fill phases push the table to
		// CAPACITY so full rejects and adds of present values on a full
		// table show up; drain phases walk it back toward empty.
		sent = 0;
		phase = 0;
		while (sent < RANDOM_ITEMS) begin
			case (phase % 3)
			0: begin
				add_cut = 85;
				remove_cut = 93;
			end
			1: begin
				add_cut = 15;
				remove_cut = 75;
			end
			default: begin
				add_cut = 40;
				remove_cut = 70;
			end
			endcase
			// phase 3 runs back to back with no gaps
			idling_on = (phase != 3);
			phase_len = $urandom_range(40, 120);
			for (int k = 0; k < phase_len && sent < RANDOM_ITEMS; k++) begin
				pick = $urandom_range(99);
				if (pick < 2)
					op = OP_UNUSED;
				else if (pick < add_cut)
					op = bst_pkg::OP_ADD;
				else if (pick < remove_cut)
					op = bst_pkg::OP_REMOVE;
				else
					op = bst_pkg::OP_SEARCH;
				// mostly pool values, some fresh noise
				if ($urandom_range(9) == 0)
					value = $urandom();
				else
					value = value_pool[$urandom_range(POOL_SIZE - 1)];
				issue_command(op, value);
				sent++;
			end
			if (phase == 0 || $urandom_range(2) == 0)
				wait_for_quiet();
			phase++;
		end

		// drain, then give the block one more lookup's worth of cycles
		wait_for_quiet();
		repeat (TABLE_DEPTH + 8) @(posedge clk);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// ~720 items in all; allow 5 ms
	initial begin
		#5_000_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule
